### design/bpd_pkg.sv
// Shared widths, constants and inter-module types for the battery power derating block.
package bpd_pkg;

	// Field widths
	localparam int PowW  = 17;
	localparam int SocW  = 14;
	localparam int MvW   = 13;
	localparam int TempW = 11;
	localparam int TmoW  = 8;
	localparam int RemW  = 17;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 17;

	// Shared multiply-divide unit: 31-bit product padded to 33 bits, three quotient bits a cycle
	localparam int ProdW    = PowW + SocW;
	localparam int DvdW     = 33;
	localparam int DivBits  = 3;
	localparam int DivIters = DvdW / DivBits;
	localparam int DivCntW  = $clog2(DivIters);

	// Bounds and constants
	localparam logic [SocW-1:0] SocFull    = 14'd10000;
	localparam logic [SocW-1:0] VHiLfp     = 14'd3500;
	localparam logic [SocW-1:0] VHiNmc     = 14'd4100;
	localparam logic [SocW-1:0] VLoLfp     = 14'd3100;
	localparam logic [SocW-1:0] VLoNmc     = 14'd3300;
	localparam logic [SocW-1:0] CellSpan   = 14'd50;
	localparam logic [SocW-1:0] LowClrHyst = 14'd25;
	localparam logic [SocW-1:0] HighClrHyst = 14'd10;
	localparam logic [RemW-1:0] RemMax     = 17'd131071;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_RATED_CHG   = 3'd0,
		REG_RATED_DIS   = 3'd1,
		REG_CHEM_LFP    = 3'd2,
		REG_MIN_SOC     = 3'd3,
		REG_CHG_TAPER   = 3'd4,
		REG_DIS_TAPER   = 3'd5,
		REG_TIMEOUT     = 3'd6,
		REG_CAPACITY    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic            start;
		logic [PowW-1:0] a;
		logic [SocW-1:0] b;
		logic [SocW-1:0] d;
	} bpd_div_req_t;

	typedef struct packed {
		logic            busy;
		logic            done;
		logic [DvdW-1:0] quo;
	} bpd_div_rsp_t;

endpackage

### design/bpd_if.sv
// Valid/ready channel interfaces for the derating input and result words.
interface bpd_in_if;
	import bpd_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [MvW-1:0]          cell_max_mv;
	logic [MvW-1:0]          cell_min_mv;
	logic signed [TempW-1:0] temp_min_dc;
	logic signed [TempW-1:0] temp_max_dc;
	logic [SocW-1:0]         soc_pptt;
	logic                    cell_reading_fresh;

	modport source (output valid, cell_max_mv, cell_min_mv, temp_min_dc, temp_max_dc,
		soc_pptt, cell_reading_fresh, input ready);
	modport sink (input valid, cell_max_mv, cell_min_mv, temp_min_dc, temp_max_dc,
		soc_pptt, cell_reading_fresh, output ready);
endinterface

interface bpd_out_if;
	import bpd_pkg::*;
	logic            valid;
	logic            ready;
	logic [PowW-1:0] charge_limit_w;
	logic [PowW-1:0] discharge_limit_w;
	logic [RemW-1:0] remaining_wh;
	logic            low_cell_trip;
	logic            high_cell_trip;
	logic            reading_expired;

	modport source (output valid, charge_limit_w, discharge_limit_w, remaining_wh,
		low_cell_trip, high_cell_trip, reading_expired, input ready);
	modport sink (input valid, charge_limit_w, discharge_limit_w, remaining_wh,
		low_cell_trip, high_cell_trip, reading_expired, output ready);
endinterface

### design/bpd_muldiv.sv
// Shared multiply then restoring divide unit: (a * b) / d, three quotient bits per cycle.
module bpd_muldiv (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpd_pkg::bpd_div_req_t req,
	output bpd_pkg::bpd_div_rsp_t rsp
);
	import bpd_pkg::*;

	logic [ProdW-1:0]   prod;
	logic [DvdW-1:0]    dvd_q;
	logic [SocW-1:0]    rem_q;
	logic [SocW-1:0]    d_q;
	logic [DivCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DvdW-1:0]    dvd_nxt;
	logic [SocW-1:0]    rem_nxt;

	assign prod = req.a * req.b;

	// Three chained compare-subtract steps; dividend shifts out the top, quotient in the bottom
	always_comb begin
		logic [SocW-1:0] r;
		logic [SocW:0]   t;
		logic [DvdW-1:0] v;
		r = rem_q;
		v = dvd_q;
		for (int k = 0; k < DivBits; k++) begin
			t = {r, v[DvdW-1]};
			v = {v[DvdW-2:0], 1'b0};
			if (t >= {1'b0, d_q}) begin
				t = t - {1'b0, d_q};
				v[0] = 1'b1;
			end
			r = t[SocW-1:0];
		end
		dvd_nxt = v;
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DivCntW'(DivIters - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load the product, then iterate
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			dvd_q <= {{(DvdW-ProdW){1'b0}}, prod};
			rem_q <= '0;
			d_q   <= req.d;
		end else if (busy_q) begin
			dvd_q <= dvd_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = dvd_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("start while divide in progress");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(busy_q) && !busy_q))
		else $error("done without a finished divide");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && d_q != '0) |-> (rem_q < d_q))
		else $error("final remainder not below divisor");

endmodule

### design/battery_power_derating.sv
// Battery power derating top level: sequencer, trip and timer state, shared multiply-divide.
//
//  channel  dir  handshake        word
//  in_ch    in   valid / ready    cell extremes, temperature extremes, SoC, fresh flag
//  out_ch   out  valid / ready    charge/discharge limits, remaining Wh, trip flags, expiry
//  cfg      in   cfg_wr_en        cfg_index selects register, cfg_data carries value
//
//  Each input word makes five passes through the shared multiply-divide unit (issue, eleven
//  3-bit divide steps, done), between an accept step and a finish step; the input channel
//  stays not ready from the accept step until the finish step returns to idle.
//  Reset (arst_n low) restores register defaults and clears trip flags, SoC and timer.
//  A finished word sits in the output register; the block takes the next input word while
//  it waits, and holds a newer result in the finish step until the output register frees.
module battery_power_derating (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bpd_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bpd_pkg::CfgDataW-1:0]  cfg_data,
	bpd_in_if.sink                        in_ch,
	bpd_out_if.source                     out_ch
);
	import bpd_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FINISH} state_t;

	// Order of the divide passes
	typedef enum logic [2:0] {
		OP_REM    = 3'd0,
		OP_CELL_C = 3'd1,
		OP_CELL_D = 3'd2,
		OP_SOC_C  = 3'd3,
		OP_SOC_D  = 3'd4
	} op_t;

	typedef logic signed [PowW+3:0] pw_t;

	function automatic pw_t min_pw(input pw_t x, input pw_t y);
		min_pw = (x < y) ? x : y;
	endfunction

	// Configuration registers
	logic [PowW-1:0] rated_chg_q, rated_dis_q, capacity_q;
	logic            lfp_q;
	logic [SocW-1:0] min_soc_q, chg_taper_q, dis_taper_q;
	logic [TmoW-1:0] timeout_q;

	// Block state
	state_t          state_q;
	op_t             op_q;
	logic            low_trip_q, high_trip_q;
	logic [SocW-1:0] soc_in_use_q;
	logic [TmoW-1:0] timer_q;

	// Output register
	logic            out_valid_q;
	logic [PowW-1:0] out_chg_q, out_dis_q;
	logic [RemW-1:0] out_rem_q;
	logic            out_low_q, out_high_q, out_exp_q;

	// Latched input word and per-pass results
	logic [MvW-1:0]          vmax_q, vmin_q;
	logic signed [TempW-1:0] tmin_q, tmax_q;
	logic [SocW-1:0]         soc_new_q;
	logic                    fresh_q;
	logic [RemW-1:0]         rem_res_q;
	logic [PowW-1:0]         q_cell_c_q, q_cell_d_q, q_soc_c_q, q_soc_d_q;
	pw_t                     t_low_q, t_high_q;

	bpd_div_req_t div_req;
	bpd_div_rsp_t div_rsp;

	logic            in_acc, out_take, out_free;
	logic [SocW-1:0] vhi, vlo, vmax_w, vmin_w;
	pw_t             tlo, rc_s, rd_s;
	pw_t             cell_c, cell_d, soc_c, soc_d, chg_min, dis_min;
	logic            low_nxt, high_nxt, expired;
	logic [TmoW-1:0] timer_eff;
	logic [PowW-1:0] chg_fin, dis_fin;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_take = out_valid_q && out_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;

	assign in_ch.ready = (state_q == S_IDLE);

	// Chemistry bounds
	assign vhi = lfp_q ? VHiLfp : VHiNmc;
	assign vlo = lfp_q ? VLoLfp : VLoNmc;
	assign tlo = lfp_q ? pw_t'(0) : pw_t'(-100);

	assign vmax_w = {{(SocW-MvW){1'b0}}, vmax_q};
	assign vmin_w = {{(SocW-MvW){1'b0}}, vmin_q};
	assign rc_s   = pw_t'({1'b0, rated_chg_q});
	assign rd_s   = pw_t'({1'b0, rated_dis_q});

	// Operand select for the shared unit; out-of-range operands give quotients that go unused
	always_comb begin
		div_req.start = (state_q == S_ISSUE);
		div_req.a     = capacity_q;
		div_req.b     = soc_in_use_q - min_soc_q;
		div_req.d     = SocFull - min_soc_q;
		case (op_q)
			OP_REM: begin
				div_req.a = capacity_q;
				div_req.b = soc_in_use_q - min_soc_q;
				div_req.d = SocFull - min_soc_q;
			end
			OP_CELL_C: begin
				div_req.a = rated_chg_q;
				div_req.b = vmax_w - (vhi - CellSpan);
				div_req.d = CellSpan;
			end
			OP_CELL_D: begin
				div_req.a = rated_dis_q;
				div_req.b = vmin_w - vlo;
				div_req.d = CellSpan;
			end
			OP_SOC_C: begin
				div_req.a = rated_chg_q;
				div_req.b = soc_in_use_q - chg_taper_q;
				div_req.d = SocFull - chg_taper_q;
			end
			OP_SOC_D: begin
				div_req.a = rated_dis_q;
				div_req.b = soc_in_use_q - min_soc_q;
				div_req.d = dis_taper_q - min_soc_q;
			end
			default: begin
				div_req.a = capacity_q;
				div_req.b = soc_in_use_q - min_soc_q;
				div_req.d = SocFull - min_soc_q;
			end
		endcase
	end

	bpd_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Tapers: below, inside or above each band
	always_comb begin
		if (vmax_w <= vhi - CellSpan)
			cell_c = rc_s;
		else if (vmax_w >= vhi)
			cell_c = '0;
		else
			cell_c = rc_s - pw_t'({1'b0, q_cell_c_q});

		if (vmin_w <= vlo)
			cell_d = '0;
		else if (vmin_w >= vlo + CellSpan)
			cell_d = rd_s;
		else
			cell_d = pw_t'({1'b0, q_cell_d_q});

		if (soc_in_use_q <= chg_taper_q)
			soc_c = rc_s;
		else if (soc_in_use_q >= SocFull)
			soc_c = '0;
		else
			soc_c = rc_s - pw_t'({1'b0, q_soc_c_q});

		if (soc_in_use_q <= min_soc_q)
			soc_d = '0;
		else if (soc_in_use_q >= dis_taper_q)
			soc_d = rd_s;
		else
			soc_d = pw_t'({1'b0, q_soc_d_q});
	end

	// Least of rated, cell taper, both temperature ramps and SoC taper
	assign chg_min = min_pw(min_pw(min_pw(rc_s, cell_c), min_pw(t_low_q, t_high_q)), soc_c);
	assign dis_min = min_pw(min_pw(min_pw(rd_s, cell_d), min_pw(t_low_q, t_high_q)), soc_d);

	// Hysteresis: trip at the bound, clear at or past the hysteresis margin
	assign low_nxt  = low_trip_q  ? !(vmin_w >= vlo + LowClrHyst) : (vmin_w <= vlo);
	assign high_nxt = high_trip_q ? !(vmax_w <= vhi - HighClrHyst) : (vmax_w >= vhi);

	// Fresh reading reloads the timer before the countdown
	assign timer_eff = fresh_q ? timeout_q : timer_q;
	assign expired   = (timer_eff == '0);

	assign chg_fin = (high_nxt || expired || chg_min < 0) ? '0 : chg_min[PowW-1:0];
	assign dis_fin = (low_nxt  || expired || dis_min < 0) ? '0 : dis_min[PowW-1:0];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rated_chg_q <= 17'd14000;
			rated_dis_q <= 17'd14000;
			lfp_q       <= 1'b0;
			min_soc_q   <= 14'd0;
			chg_taper_q <= 14'd9000;
			dis_taper_q <= 14'd1000;
			timeout_q   <= 8'd60;
			capacity_q  <= 17'd16600;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				REG_RATED_CHG: rated_chg_q <= cfg_data[PowW-1:0];
				REG_RATED_DIS: rated_dis_q <= cfg_data[PowW-1:0];
				REG_CHEM_LFP:  lfp_q       <= cfg_data[0];
				REG_MIN_SOC:   min_soc_q   <= cfg_data[SocW-1:0];
				REG_CHG_TAPER: chg_taper_q <= cfg_data[SocW-1:0];
				REG_DIS_TAPER: dis_taper_q <= cfg_data[SocW-1:0];
				REG_TIMEOUT:   timeout_q   <= cfg_data[TmoW-1:0];
				REG_CAPACITY:  capacity_q  <= cfg_data[PowW-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, block state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_REM;
			low_trip_q   <= 1'b0;
			high_trip_q  <= 1'b0;
			soc_in_use_q <= '0;
			timer_q      <= '0;
			out_valid_q  <= 1'b0;
			out_chg_q    <= '0;
			out_dis_q    <= '0;
			out_rem_q    <= '0;
			out_low_q    <= 1'b0;
			out_high_q   <= 1'b0;
			out_exp_q    <= 1'b0;
		end else begin
			// Drop the taken word; a finish in the same cycle reloads the register below
			if (out_take && state_q != S_FINISH)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q    <= OP_REM;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						if (op_q == OP_SOC_D) begin
							state_q <= S_FINISH;
						end else begin
							op_q    <= op_t'(op_q + 3'd1);
							state_q <= S_ISSUE;
						end
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_chg_q    <= chg_fin;
						out_dis_q    <= dis_fin;
						out_rem_q    <= rem_res_q;
						out_low_q    <= low_nxt;
						out_high_q   <= high_nxt;
						out_exp_q    <= expired;
						low_trip_q   <= low_nxt;
						high_trip_q  <= high_nxt;
						soc_in_use_q <= soc_new_q;
						timer_q      <= expired ? '0 : timer_eff - 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Input latch, temperature ramps and pass results
	always_ff @(posedge clk) begin
		if (in_acc) begin
			vmax_q    <= in_ch.cell_max_mv;
			vmin_q    <= in_ch.cell_min_mv;
			tmin_q    <= in_ch.temp_min_dc;
			tmax_q    <= in_ch.temp_max_dc;
			soc_new_q <= in_ch.soc_pptt;
			fresh_q   <= in_ch.cell_reading_fresh;
		end
		t_low_q  <= pw_t'((pw_t'(tmin_q) - tlo) * pw_t'(280));
		t_high_q <= pw_t'((pw_t'(500) - pw_t'(tmax_q)) * pw_t'(140));
		if (state_q == S_WAIT && div_rsp.done) begin
			case (op_q)
				OP_REM: begin
					// Zero at or below the minimum SoC or with no span left; saturate above
					if (soc_in_use_q <= min_soc_q || min_soc_q >= SocFull)
						rem_res_q <= '0;
					else if (div_rsp.quo > DvdW'(RemMax))
						rem_res_q <= RemMax;
					else
						rem_res_q <= div_rsp.quo[RemW-1:0];
				end
				OP_CELL_C: q_cell_c_q <= div_rsp.quo[PowW-1:0];
				OP_CELL_D: q_cell_d_q <= div_rsp.quo[PowW-1:0];
				OP_SOC_C:  q_soc_c_q  <= div_rsp.quo[PowW-1:0];
				OP_SOC_D:  q_soc_d_q  <= div_rsp.quo[PowW-1:0];
				default: ;
			endcase
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.charge_limit_w    = out_chg_q;
	assign out_ch.discharge_limit_w = out_dis_q;
	assign out_ch.remaining_wh      = out_rem_q;
	assign out_ch.low_cell_trip     = out_low_q;
	assign out_ch.high_cell_trip    = out_high_q;
	assign out_ch.reading_expired   = out_exp_q;

	a_issue_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ISSUE) |-> !div_rsp.busy)
		else $error("issue while shared unit busy");

	a_expired_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_exp_q) |-> (out_chg_q == '0 && out_dis_q == '0))
		else $error("expired word carries nonzero limits");

	a_trip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((!out_high_q || out_chg_q == '0) && (!out_low_q || out_dis_q == '0)))
		else $error("tripped word carries nonzero limit");

	a_finish_last_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) |-> (op_q == OP_SOC_D))
		else $error("finish before last divide pass");

endmodule

### tb/battery_power_derating_tb.sv
// Self-checking testbench for the battery power derating block: predicts every result word.
`timescale 1ns / 100ps

module battery_power_derating_tb;
	import bpd_pkg::*;

	// Handshake pacing of a phase
	typedef enum logic [1:0] {
		PACE_FREE,
		PACE_SEND_IDLE,
		PACE_RECV_STALL,
		PACE_BOTH
	} pace_t;

	typedef struct packed {
		logic [MvW-1:0]   cell_max_mv;
		logic [MvW-1:0]   cell_min_mv;
		logic [TempW-1:0] temp_min_dc;
		logic [TempW-1:0] temp_max_dc;
		logic [SocW-1:0]  soc_pptt;
		logic             cell_reading_fresh;
	} tick_t;

	typedef struct packed {
		logic [PowW-1:0] charge_limit_w;
		logic [PowW-1:0] discharge_limit_w;
		logic [RemW-1:0] remaining_wh;
		logic            low_cell_trip;
		logic            high_cell_trip;
		logic            reading_expired;
	} limits_t;

	// Derating constants held as 64-bit signed so the arithmetic never wraps
	localparam longint FullSoc    = longint'(SocFull);
	localparam longint RemCap     = longint'(RemMax);
	localparam longint Span       = longint'(CellSpan);
	localparam longint LowClr     = longint'(LowClrHyst);
	localparam longint HighClr    = longint'(HighClrHyst);
	localparam longint TempLoLfp  = 0;
	localparam longint TempLoNmc  = -100;
	localparam longint LowSlope   = 280;
	localparam longint HighSlope  = 140;
	localparam longint HighRef    = 500;

	localparam int StallLimit = 4000;   // cycles with no word moving on either channel
	localparam int DrainPause = 100;    // one full derating pass plus margin
	localparam int NumPhases  = 8;
	localparam int PhaseWords = 122;

	logic clk = 1'b0;
	logic arst_n;
	logic                cfg_wr_en;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	bpd_in_if  in_ch();
	bpd_out_if out_ch();

	battery_power_derating dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the registers, updated as each write goes out
	logic [PowW-1:0] rated_chg_w   = 17'd14000;
	logic [PowW-1:0] rated_dis_w   = 17'd14000;
	logic            lfp_sel       = 1'b0;
	logic [SocW-1:0] min_soc       = 14'd0;
	logic [SocW-1:0] chg_taper_soc = 14'd9000;
	logic [SocW-1:0] dis_taper_soc = 14'd1000;
	logic [TmoW-1:0] read_tmo      = 8'd60;
	logic [RemW-1:0] capacity_wh   = 17'd16600;

	// Predicted block state
	logic            low_trip   = 1'b0;
	logic            high_trip  = 1'b0;
	logic [SocW-1:0] soc_prev   = '0;
	logic [TmoW-1:0] read_timer = '0;

	tick_t   pending_ticks[$];
	limits_t expected_limits[$];

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	int  stale_left     = 0;
	int  n_words        = 0;
	int  n_expired      = 0;
	int  n_tripped      = 0;
	int  n_mismatch     = 0;
	int  quiet_cycles   = 0;
	logic in_fire  = 1'b0;
	logic out_fire = 1'b0;

	function automatic longint least(longint a, longint b);
		return (a < b) ? a : b;
	endfunction

	function automatic int clip(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Linear taper between two points; signed division truncates toward zero
	function automatic longint taper_lin(longint x, longint x_lo, longint x_hi,
			longint y_lo, longint y_hi);
		if (x <= x_lo) return y_lo;
		if (x >= x_hi) return y_hi;
		return y_lo + ((y_hi - y_lo) * (x - x_lo)) / (x_hi - x_lo);
	endfunction

	// Work out one result word and advance the trip, SoC and timer state
	task automatic predict_limits(input tick_t w, output limits_t r);
		longint vmax, vmin, tmin, tmax, vhi, vlo, tlo, rc, rd, soc, smin;
		longint rem, chg, dis, cell_c, cell_d, t_low, t_high;
		logic expired;
		vmax = longint'(w.cell_max_mv);
		vmin = longint'(w.cell_min_mv);
		tmin = longint'($signed(w.temp_min_dc));
		tmax = longint'($signed(w.temp_max_dc));
		rc   = longint'(rated_chg_w);
		rd   = longint'(rated_dis_w);
		soc  = longint'(soc_prev);
		smin = longint'(min_soc);
		vhi  = lfp_sel ? longint'(VHiLfp) : longint'(VHiNmc);
		vlo  = lfp_sel ? longint'(VLoLfp) : longint'(VLoNmc);
		tlo  = lfp_sel ? TempLoLfp : TempLoNmc;
		expired = 1'b0;

		// A fresh reading reloads the timer before anything else
		if (w.cell_reading_fresh) read_timer = read_tmo;

		rem = 0;
		if (soc > smin && smin < FullSoc) begin
			rem = (longint'(capacity_wh) * (soc - smin)) / (FullSoc - smin);
			if (rem > RemCap) rem = RemCap;
		end

		cell_c = taper_lin(vmax, vhi - Span, vhi, rc, 0);
		cell_d = taper_lin(vmin, vlo, vlo + Span, 0, rd);

		if (low_trip && vmin >= vlo + LowClr) begin
			low_trip = 1'b0;
		end else if (!low_trip && vmin <= vlo) begin
			low_trip = 1'b1;
			cell_d = 0;
		end
		if (high_trip && vmax <= vhi - HighClr) begin
			high_trip = 1'b0;
		end else if (!high_trip && vmax >= vhi) begin
			high_trip = 1'b1;
			cell_c = 0;
		end
		chg = least(rc, cell_c);
		dis = least(rd, cell_d);

		t_low  = (tmin - tlo) * LowSlope;
		t_high = (HighRef - tmax) * HighSlope;
		chg = least(least(chg, t_low), t_high);
		dis = least(least(dis, t_low), t_high);

		chg = least(chg, taper_lin(soc, longint'(chg_taper_soc), FullSoc, rc, 0));
		dis = least(dis, taper_lin(soc, smin, longint'(dis_taper_soc), 0, rd));

		if (low_trip) dis = 0;
		if (high_trip) chg = 0;
		soc_prev = w.soc_pptt;

		if (chg < 0) chg = 0;
		if (dis < 0) dis = 0;

		if (read_timer != 0) begin
			read_timer = read_timer - 1'b1;
		end else begin
			chg = 0;
			dis = 0;
			expired = 1'b1;
		end

		r.charge_limit_w    = PowW'(chg);
		r.discharge_limit_w = PowW'(dis);
		r.remaining_wh      = RemW'(rem);
		r.low_cell_trip     = low_trip;
		r.high_cell_trip    = high_trip;
		r.reading_expired   = expired;
	endtask

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_mismatch++;
		end
	endfunction

	// Queue one word for the driver
	task automatic push_tick(int vmax, int vmin, int tmin, int tmax, int soc, bit fresh);
		tick_t w;
		w.cell_max_mv        = MvW'(vmax);
		w.cell_min_mv        = MvW'(vmin);
		w.temp_min_dc        = TempW'(tmin);
		w.temp_max_dc        = TempW'(tmax);
		w.soc_pptt           = SocW'(soc);
		w.cell_reading_fresh = fresh;
		pending_ticks.push_back(w);
	endtask

	// Random word aimed at the voltage bounds, temperature ramps and SoC tapers
	// of the current register setting; a few take voltages anywhere in their field range.
	task automatic push_random_tick();
		int vhi, vlo, tlo, vmax, vmin, tmin, tmax, soc, sel;
		bit fresh;
		vhi = lfp_sel ? int'(VHiLfp) : int'(VHiNmc);
		vlo = lfp_sel ? int'(VLoLfp) : int'(VLoNmc);
		tlo = lfp_sel ? int'(TempLoLfp) : int'(TempLoNmc);

		if ($urandom_range(9) < 2) begin
			vmax = $urandom_range(8191);
			vmin = $urandom_range(8191);
		end else begin
			vmax = vhi - 60 + $urandom_range(70);
			vmin = vlo - 10 + $urandom_range(70);
		end

		if ($urandom_range(9) < 2) begin
			tmin = int'($urandom_range(1295)) - 400;
			tmax = int'($urandom_range(1295)) - 400;
		end else begin
			tmin = tlo - 30 + $urandom_range(380);
			tmax = 350 + $urandom_range(170);
		end

		sel = $urandom_range(9);
		if (sel < 4)
			soc = $urandom_range(10210);
		else if (sel < 7)
			soc = clip(int'(chg_taper_soc) - 300 + $urandom_range(1000), 0, 10210);
		else
			soc = clip(int'(min_soc) - 300 + $urandom_range(600 + int'(dis_taper_soc)),
				0, 10210);

		// Hold off fresh readings now and then so the timer can run out
		if (stale_left > 0) begin
			stale_left--;
			fresh = 1'b0;
		end else if ($urandom_range(99) < 5) begin
			stale_left = $urandom_range(clip(int'(read_tmo), 0, 20) + 3, 1);
			fresh = 1'b0;
		end else begin
			fresh = 1'b1;
		end
		push_tick(vmax, vmin, tmin, tmax, soc, fresh);
	endtask

	task automatic set_pace(pace_t p);
		case (p)
			PACE_FREE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			PACE_SEND_IDLE: begin
				send_idle_pct = 85;
				recv_stall_pct = 0;
			end
			PACE_RECV_STALL: begin
				send_idle_pct = 0;
				recv_stall_pct = 85;
			end
			default: begin
				send_idle_pct = 28;
				recv_stall_pct = 28;
			end
		endcase
	endtask

	// Hold until every queued word has gone in and every result word has come back
	task automatic drain();
		do @(posedge clk);
		while (pending_ticks.size() != 0 || in_ch.valid || expected_limits.size() != 0);
	endtask

	task automatic write_reg(cfg_idx_t idx, int unsigned value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CfgDataW'(value);
		case (idx)
			REG_RATED_CHG: rated_chg_w   = PowW'(value);
			REG_RATED_DIS: rated_dis_w   = PowW'(value);
			REG_CHEM_LFP:  lfp_sel       = value[0];
			REG_MIN_SOC:   min_soc       = SocW'(value);
			REG_CHG_TAPER: chg_taper_soc = SocW'(value);
			REG_DIS_TAPER: dis_taper_soc = SocW'(value);
			REG_TIMEOUT:   read_tmo      = TmoW'(value);
			default:       capacity_wh   = RemW'(value);
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic load_setting(int unsigned rc, int unsigned rd, int unsigned lfp,
			int unsigned smin, int unsigned ctap, int unsigned dtap,
			int unsigned tmo, int unsigned cap);
		write_reg(REG_RATED_CHG, rc);
		write_reg(REG_RATED_DIS, rd);
		write_reg(REG_CHEM_LFP, lfp);
		write_reg(REG_MIN_SOC, smin);
		write_reg(REG_CHG_TAPER, ctap);
		write_reg(REG_DIS_TAPER, dtap);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_CAPACITY, cap);
	endtask

	// Input driver: present the next word at the falling edge, hold it until taken.
	// The reset branch also puts known values on every channel input while reset is held.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid              <= 1'b0;
			in_ch.cell_max_mv        <= '0;
			in_ch.cell_min_mv        <= '0;
			in_ch.temp_min_dc        <= '0;
			in_ch.temp_max_dc        <= '0;
			in_ch.soc_pptt           <= '0;
			in_ch.cell_reading_fresh <= 1'b0;
			out_ch.ready             <= 1'b0;
		end else begin
			if (in_ch.valid && !in_fire) begin
				// word still waiting: leave it on the bus
			end else if (pending_ticks.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				in_ch.valid              <= 1'b1;
				in_ch.cell_max_mv        <= pending_ticks[0].cell_max_mv;
				in_ch.cell_min_mv        <= pending_ticks[0].cell_min_mv;
				in_ch.temp_min_dc        <= pending_ticks[0].temp_min_dc;
				in_ch.temp_max_dc        <= pending_ticks[0].temp_max_dc;
				in_ch.soc_pptt           <= pending_ticks[0].soc_pptt;
				in_ch.cell_reading_fresh <= pending_ticks[0].cell_reading_fresh;
				void'(pending_ticks.pop_front());
			end else begin
				in_ch.valid <= 1'b0;
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predict on each accepted input word, check each accepted result word
	always @(posedge clk) begin : monitor
		tick_t   w;
		limits_t want;
		limits_t got;
		in_fire  = arst_n && in_ch.valid && in_ch.ready;
		out_fire = arst_n && out_ch.valid && out_ch.ready;

		if (in_fire) begin
			w.cell_max_mv        = in_ch.cell_max_mv;
			w.cell_min_mv        = in_ch.cell_min_mv;
			w.temp_min_dc        = in_ch.temp_min_dc;
			w.temp_max_dc        = in_ch.temp_max_dc;
			w.soc_pptt           = in_ch.soc_pptt;
			w.cell_reading_fresh = in_ch.cell_reading_fresh;
			predict_limits(w, want);
			expected_limits.push_back(want);
			n_words++;
			if (want.reading_expired) n_expired++;
			if (want.low_cell_trip || want.high_cell_trip) n_tripped++;
		end

		if (out_fire) begin
			got.charge_limit_w    = out_ch.charge_limit_w;
			got.discharge_limit_w = out_ch.discharge_limit_w;
			got.remaining_wh      = out_ch.remaining_wh;
			got.low_cell_trip     = out_ch.low_cell_trip;
			got.high_cell_trip    = out_ch.high_cell_trip;
			got.reading_expired   = out_ch.reading_expired;
			if (expected_limits.size() == 0) begin
				$error("result word with no prediction pending");
				n_mismatch++;
			end else begin
				want = expected_limits.pop_front();
				check_field("charge_limit_w", want.charge_limit_w, got.charge_limit_w);
				check_field("discharge_limit_w", want.discharge_limit_w,
					got.discharge_limit_w);
				check_field("remaining_wh", want.remaining_wh, got.remaining_wh);
				check_field("low_cell_trip", want.low_cell_trip, got.low_cell_trip);
				check_field("high_cell_trip", want.high_cell_trip, got.high_cell_trip);
				check_field("reading_expired", want.reading_expired, got.reading_expired);
			end
		end

		// Watchdog: give up when neither channel moves a word for too long
		if (in_fire || out_fire || !arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= StallLimit) begin
				$display("watchdog: no word moved for %0d cycles", StallLimit);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int left, chunk;
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words on the reset setting (NMC bounds, timer starting at zero)
		set_pace(PACE_FREE);
		push_tick(3900, 3600, 200, 300, 5000, 0);    // stale from reset: expired
		push_tick(3900, 3600, 200, 300, 5000, 1);
		push_tick(4060, 3600, 200, 300, 9500, 1);    // charge voltage taper
		push_tick(4100, 3600, 200, 300, 10000, 1);   // high trip sets
		push_tick(4095, 3600, 200, 300, 10210, 1);   // inside hysteresis, stays set
		push_tick(4090, 3600, 200, 300, 0, 1);       // high trip clears
		push_tick(3900, 3340, 200, 300, 500, 1);     // discharge voltage taper
		push_tick(3900, 3300, 200, 300, 500, 1);     // low trip sets
		push_tick(3900, 3324, 200, 300, 1500, 1);    // inside hysteresis, stays set
		push_tick(3900, 3325, 200, 300, 1500, 1);    // low trip clears
		push_tick(3900, 3600, -100, 500, 5000, 1);   // both temperature ramps at zero
		push_tick(3900, 3600, -400, 895, 5000, 1);   // negative limits clamp to zero
		push_tick(3900, 3600, -60, 450, 5000, 1);    // both ramps active
		push_tick(8191, 8191, 895, 895, 10210, 1);   // voltage fields at their top, temperatures and SoC high
		push_tick(0, 0, -400, -400, 0, 0);           // voltage and SoC fields at their bottom, temperatures low
		push_tick(8191, 0, 895, -400, 8192, 1);
		push_tick(3900, 3600, 200, 300, 9999, 0);
		push_tick(3900, 3600, 200, 300, 1, 1);
		drain();

		// Random phases, each with its own register setting and one of four pacing modes
		for (int p = 0; p < NumPhases; p++) begin
			case (p)
				0: load_setting(0, 0, 0, 0, 0, 0, 0, 0);
				1: load_setting(100000, 100000, 1, 9999, 9999, 10000, 255, 100000);
				2: load_setting(14000, 14000, 0, 500, 9000, 1500, 3, 16600);
				default: load_setting($urandom_range(100000), $urandom_range(100000),
					$urandom_range(1), $urandom_range(3000), $urandom_range(9999, 5000),
					$urandom_range(10000), $urandom_range(12, 1), $urandom_range(100000));
			endcase
			// Discharge taper bound below the minimum SoC: bounds in the wrong order
			if (p == 5) begin
				write_reg(REG_MIN_SOC, 6000);
				write_reg(REG_DIS_TAPER, 2000);
			end
			set_pace(pace_t'(p % 4));
			stale_left = 0;

			// Feed in bursts; after the first burst and at random, pause the
			// sender until every result word is back
			left = PhaseWords;
			while (left > 0) begin
				chunk = (left < 40) ? left : $urandom_range(40, 10);
				repeat (chunk) push_random_tick();
				left -= chunk;
				while (pending_ticks.size() != 0) @(posedge clk);
				if (left == PhaseWords - chunk || $urandom_range(3) == 0) drain();
			end
			drain();
		end

		repeat (DrainPause) @(posedge clk);
		$display("derating run: %0d words over %0d register settings and 4 pacing modes",
			n_words, NumPhases + 1);
		$display("  %0d with reading expired, %0d with a trip flag set, %0d mismatches",
			n_expired, n_tripped, n_mismatch);
		if (n_mismatch == 0 && expected_limits.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### battery_power_derating.f
design/bpd_pkg.sv
design/bpd_if.sv
design/bpd_muldiv.sv
design/battery_power_derating.sv
tb/battery_power_derating_tb.sv
